[src/kcf_pkg.sv]
// Shared constants and types for the four-quadrant Kuwahara color filter.
// Holds register indexes, field widths, reset values and the queue status type.
// No dependencies.
package kcf_pkg;

    localparam int PIX_W        = 8;
    localparam int NCH          = 3;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int FW_W         = 12;
    localparam int FH_W         = 13;
    localparam int RAD_W        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

    localparam logic [FW_W-1:0]  FW_RESET  = 12'd640;
    localparam logic [FH_W-1:0]  FH_RESET  = 13'd480;
    localparam logic [RAD_W-1:0] RAD_RESET = 3'd3;

    localparam int HEIGHT_LIMIT = 4096;

    localparam int QDEPTH       = 4;
    localparam int QAW          = 2;
    localparam int QCW          = 3;

    typedef struct packed {
        logic [QCW-1:0] level;
        logic           busy;
    } t_q_status;

endpackage

[src/kcf_job_queue.sv]
// Short job queue between the filter front and back.
// Depends on kcf_pkg for depth and pointer widths.
module kcf_job_queue import kcf_pkg::*; #(
    parameter int JW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [JW-1:0] i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [JW-1:0] o_data,
    output logic [QCW-1:0] o_level
);

    logic [JW-1:0]  r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + QCW'(1);
                2'b01:   r_level <= r_level - QCW'(1);
                default: r_level <= r_level;
            endcase
        end
    end

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= QCW'(QDEPTH)) else $error("queue level above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_level != QCW'(QDEPTH)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_level != '0) else $error("pop from empty queue");
`endif

endmodule

[src/kcf_front.sv]
// Front of the Kuwahara filter: config registers, input and output position
// counters, line store writes and classification of each due result.
// Depends on kcf_pkg.
module kcf_front import kcf_pkg::*; #(
    parameter  int MAX_WIDTH  = 2048,
    parameter  int MAX_RADIUS = 4,
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int CLW   = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_RADIUS + 1),
    localparam int SLOTS = 2 * MAX_RADIUS + 1,
    localparam int SLW   = $clog2(SLOTS),
    localparam int AW    = $clog2(SLOTS * MAX_WIDTH),
    localparam int JW    = 2 + SLW + CLW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_blue_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic                  i_flush,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_status             i_status,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [3*PIX_W-1:0]    o_wr_data,
    output logic                  o_push,
    output logic [JW-1:0]         o_job,
    output logic [RW-1:0]         o_radius
);

    localparam int LAG_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
    localparam int DW      = $clog2(LAG_MAX + 1);

    logic [FW_W-1:0]  r_width;
    logic [FH_W-1:0]  r_height;
    logic [RAD_W-1:0] r_radius;
    logic [CLW-1:0]   r_in_col;
    logic [CLW-1:0]   r_out_col;
    logic [FH_W-1:0]  r_in_row;
    logic [FH_W-1:0]  r_out_row;
    logic [SLW-1:0]   r_in_slot;
    logic [SLW-1:0]   r_out_slot;
    logic [DW-1:0]    r_diff;

    logic [WW-1:0]    w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [RW-1:0]    rad_eff;
    logic [DW-1:0]    lag;
    logic             in_active;
    logic             ignore;
    logic             will_emit;
    logic [QCW-1:0]   pending;
    logic             accept;
    logic             step;
    logic             emit;
    logic             cfg_hit;
    logic             in_last_col;
    logic             out_last_col;
    logic             is_pass;
    logic             is_done;

    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = FH_W'(1);
        end else if (32'(r_height) > 32'(HEIGHT_LIMIT)) begin
            h_eff = FH_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_height;
        end
        if (32'(r_radius) > 32'(MAX_RADIUS)) begin
            rad_eff = RW'(MAX_RADIUS);
        end else begin
            rad_eff = RW'(r_radius);
        end
        lag = DW'(32'(rad_eff) * 32'(w_eff) + 32'(rad_eff));
    end

    assign in_active = (r_in_row < h_eff);
    assign ignore    = in_active && i_flush;
    assign will_emit = !ignore && (r_diff >= lag);
    assign pending   = i_status.level + QCW'(i_status.busy);
    assign o_stall   = (i_status.level == QCW'(QDEPTH))
                    || ((pending != '0)
                        && (!will_emit
                            || ((r_in_row == '0) && (r_in_col == '0))
                            || (32'(pending) + 32'd2 * 32'(lag)
                                >= 32'(SLOTS) * 32'(w_eff))));
    assign accept    = i_valid && !o_stall;
    assign step      = accept && !ignore;
    assign emit      = step && will_emit;
    assign cfg_hit   = i_cfg_we
                    && (i_cfg_idx inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_RADIUS});

    assign in_last_col  = (32'(r_in_col) + 32'd1 >= 32'(w_eff));
    assign out_last_col = (32'(r_out_col) + 32'd1 >= 32'(w_eff));

    assign is_pass = (32'(r_out_row) < 32'(rad_eff))
                  || (32'(r_out_row) + 32'(rad_eff) >= 32'(h_eff))
                  || (32'(r_out_col) < 32'(rad_eff))
                  || (32'(r_out_col) + 32'(rad_eff) >= 32'(w_eff));
    assign is_done = (32'(r_out_row) + 32'd1 == 32'(h_eff)) && out_last_col;

    assign o_wr_en   = accept && in_active && !i_flush;
    assign o_wr_addr = AW'(32'(r_in_slot) * 32'(MAX_WIDTH) + 32'(r_in_col));
    assign o_wr_data = {i_red_in, i_green_in, i_blue_in};
    assign o_push    = emit;
    assign o_job     = {is_pass, is_done, r_out_slot, r_out_col};
    assign o_radius  = rad_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= FW_RESET;
            r_height   <= FH_RESET;
            r_radius   <= RAD_RESET;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_diff     <= '0;
        end else if (cfg_hit) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[FH_W-1:0];
                CFG_RADIUS:       r_radius <= i_cfg_data[RAD_W-1:0];
                default:          r_width  <= r_width;
            endcase
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_diff     <= '0;
        end else if (step) begin
            if (emit && is_done) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_slot  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
                r_diff     <= '0;
            end else begin
                if (in_last_col) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + FH_W'(1);
                    r_in_slot <= (r_in_slot == SLW'(SLOTS - 1)) ? '0 : r_in_slot + SLW'(1);
                end else begin
                    r_in_col <= r_in_col + CLW'(1);
                end
                if (emit) begin
                    if (out_last_col) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + FH_W'(1);
                        r_out_slot <= (r_out_slot == SLW'(SLOTS - 1)) ? '0
                                    : r_out_slot + SLW'(1);
                    end else begin
                        r_out_col <= r_out_col + CLW'(1);
                    end
                end else begin
                    r_diff <= r_diff + DW'(1);
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_diff_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_diff <= lag) else $error("input lead exceeds lag");
    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_row <= r_in_row) else $error("output row ahead of input row");
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_valid && !o_stall && !o_wr_en) || (i_valid && !o_stall && in_active)
        || (i_valid && !o_stall)) else $error("job pushed without an accepted word");
`endif

endmodule

[src/kcf_back.sv]
// Back of the Kuwahara filter: line store memory, quadrant sums over the
// single read port, variance compare, rounded mean divider and output register.
// Depends on kcf_pkg.
module kcf_back import kcf_pkg::*; #(
    parameter  int MAX_WIDTH  = 2048,
    parameter  int MAX_RADIUS = 4,
    localparam int CLW   = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_RADIUS + 1),
    localparam int SLOTS = 2 * MAX_RADIUS + 1,
    localparam int SLW   = $clog2(SLOTS),
    localparam int AW    = $clog2(SLOTS * MAX_WIDTH),
    localparam int JW    = 2 + SLW + CLW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [3*PIX_W-1:0] i_wr_data,
    input  logic               i_job_valid,
    input  logic [JW-1:0]      i_job,
    output logic               o_pop,
    input  logic [RW-1:0]      i_radius,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PIX_W-1:0]   o_blue_out,
    output logic [PIX_W-1:0]   o_green_out,
    output logic [PIX_W-1:0]   o_red_out,
    output logic               o_frame_done
);

    localparam int NMAX = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
    localparam int NW   = $clog2(NMAX + 1);
    localparam int SW   = $clog2(255 * NMAX + 1);
    localparam int QW   = $clog2(65025 * NMAX + 1);
    localparam int PW   = NW + QW;
    localparam int VW   = PW + 2;
    localparam int DCW  = $clog2(SW + 1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PASS_RD  = 4'd1;
    localparam logic [3:0] ST_PASS_OUT = 4'd2;
    localparam logic [3:0] ST_PREP     = 4'd3;
    localparam logic [3:0] ST_SUM      = 4'd4;
    localparam logic [3:0] ST_DRAIN    = 4'd5;
    localparam logic [3:0] ST_VAR      = 4'd6;
    localparam logic [3:0] ST_CMP      = 4'd7;
    localparam logic [3:0] ST_DIV      = 4'd8;
    localparam logic [3:0] ST_ROUND    = 4'd9;

    logic [3*PIX_W-1:0] r_mem [SLOTS * MAX_WIDTH];
    logic [3*PIX_W-1:0] r_rd_data;

    logic [3:0]     r_state;
    logic [3:0]     n_state;
    logic           r_done;
    logic [SLW-1:0] r_slot;
    logic [CLW-1:0] r_col;
    logic [1:0]     r_quad;
    logic [RW-1:0]  r_dx;
    logic [RW-1:0]  r_dy;
    logic [SLW-1:0] r_rd_slot;
    logic [CLW-1:0] r_rd_col;
    logic [CLW-1:0] r_col0;
    logic           r_vld1;
    logic [SW-1:0]  r_sum [NCH];
    logic [QW-1:0]  r_sq  [NCH];
    logic [1:0]     r_ch;
    logic [PW-1:0]  r_pa;
    logic [PW-1:0]  r_pb;
    logic [VW-1:0]  r_var;
    logic [VW-1:0]  r_best_var;
    logic [SW-1:0]  r_dvd [NCH];
    logic [NW-1:0]  r_rem [NCH];
    logic [SW-1:0]  r_quo [NCH];
    logic [DCW-1:0] r_div_cnt;
    logic           r_o_valid;
    logic [PIX_W-1:0] r_o_pix [NCH];
    logic           r_o_done;

    logic [NW-1:0]      n_val;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               out_free;
    logic               out_load;
    logic [1:0]         ch_sel;
    logic               job_pass;
    logic [SLW-1:0]     top_slot;
    logic [CLW-1:0]     start_col;
    logic [NW:0]        rem_sh [NCH];
    logic               rem_ge [NCH];
    logic [PIX_W-1:0]   mean [NCH];
    logic [SW:0]        q_round [NCH];
    logic               round_up [NCH];

    assign n_val    = NW'((32'(i_radius) + 32'd1) * (32'(i_radius) + 32'd1));
    assign job_pass = i_job[JW-1];
    assign o_pop    = (r_state == ST_IDLE) && i_job_valid;
    assign o_busy   = (r_state != ST_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign out_load = out_free && ((r_state == ST_PASS_OUT) || (r_state == ST_ROUND));
    assign ch_sel   = (r_ch == 2'd3) ? 2'd0 : r_ch;

    always_comb begin
        if (!r_quad[1]) begin
            if (32'(r_slot) >= 32'(i_radius)) begin
                top_slot = SLW'(32'(r_slot) - 32'(i_radius));
            end else begin
                top_slot = SLW'(32'(r_slot) + 32'(SLOTS) - 32'(i_radius));
            end
        end else begin
            top_slot = r_slot;
        end
        if (!r_quad[0]) begin
            start_col = CLW'(32'(r_col) - 32'(i_radius));
        end else begin
            start_col = r_col;
        end
    end

    always_comb begin
        rd_en   = (r_state == ST_PASS_RD) || (r_state == ST_SUM);
        if (r_state == ST_PASS_RD) begin
            rd_addr = AW'(32'(r_slot) * 32'(MAX_WIDTH) + 32'(r_col));
        end else begin
            rd_addr = AW'(32'(r_rd_slot) * 32'(MAX_WIDTH) + 32'(r_rd_col));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            rem_sh[c]   = {r_rem[c], r_dvd[c][SW-1]};
            rem_ge[c]   = (rem_sh[c] >= {1'b0, n_val});
            round_up[c] = ({r_rem[c], 1'b0} > {1'b0, n_val})
                       || (({r_rem[c], 1'b0} == {1'b0, n_val}) && r_quo[c][0]);
            q_round[c]  = {1'b0, r_quo[c]} + (SW + 1)'(round_up[c]);
            mean[c]     = (q_round[c] > (SW + 1)'(255)) ? 8'hFF : q_round[c][PIX_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = job_pass ? ST_PASS_RD : ST_PREP;
                end
            end
            ST_PASS_RD:  n_state = ST_PASS_OUT;
            ST_PASS_OUT: n_state = out_free ? ST_IDLE : ST_PASS_OUT;
            ST_PREP:     n_state = ST_SUM;
            ST_SUM: begin
                if ((r_dx == i_radius) && (r_dy == i_radius)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:    n_state = ST_VAR;
            ST_VAR:      n_state = (r_ch == 2'd3) ? ST_CMP : ST_VAR;
            ST_CMP:      n_state = (r_quad == 2'd3) ? ST_DIV : ST_PREP;
            ST_DIV:      n_state = (r_div_cnt == DCW'(SW - 1)) ? ST_ROUND : ST_DIV;
            ST_ROUND:    n_state = out_free ? ST_IDLE : ST_ROUND;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vld1  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld1  <= (r_state == ST_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_done <= i_job[JW-2];
                r_slot <= i_job[CLW +: SLW];
                r_col  <= i_job[CLW-1:0];
                r_quad <= 2'd0;
            end
            ST_PREP: begin
                r_rd_slot <= top_slot;
                r_rd_col  <= start_col;
                r_col0    <= start_col;
                r_dx      <= '0;
                r_dy      <= '0;
                r_var     <= '0;
                r_ch      <= 2'd0;
            end
            ST_SUM: begin
                if (r_dx == i_radius) begin
                    r_dx     <= '0;
                    r_rd_col <= r_col0;
                    r_dy     <= r_dy + RW'(1);
                    r_rd_slot <= (r_rd_slot == SLW'(SLOTS - 1)) ? '0
                               : r_rd_slot + SLW'(1);
                end else begin
                    r_dx     <= r_dx + RW'(1);
                    r_rd_col <= r_rd_col + CLW'(1);
                end
            end
            ST_VAR: begin
                r_pa <= PW'(n_val) * PW'(r_sq[ch_sel]);
                r_pb <= PW'(r_sum[ch_sel]) * PW'(r_sum[ch_sel]);
                if (r_ch != 2'd0) begin
                    r_var <= r_var + VW'(r_pa) - VW'(r_pb);
                end
                r_ch <= r_ch + 2'd1;
            end
            ST_CMP: begin
                if ((r_quad == 2'd0) || (r_var < r_best_var)) begin
                    r_best_var <= r_var;
                    for (int c = 0; c < NCH; c++) begin
                        r_dvd[c] <= r_sum[c];
                    end
                end
                r_quad    <= r_quad + 2'd1;
                r_div_cnt <= '0;
                for (int c = 0; c < NCH; c++) begin
                    r_rem[c] <= '0;
                    r_quo[c] <= '0;
                end
            end
            ST_DIV: begin
                r_div_cnt <= r_div_cnt + DCW'(1);
                for (int c = 0; c < NCH; c++) begin
                    r_dvd[c] <= {r_dvd[c][SW-2:0], 1'b0};
                    r_rem[c] <= rem_ge[c] ? NW'(rem_sh[c] - {1'b0, n_val}) : NW'(rem_sh[c]);
                    r_quo[c] <= {r_quo[c][SW-2:0], rem_ge[c]};
                end
            end
            default: begin
                r_ch <= r_ch;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NCH; c++) begin
            if (r_state == ST_PREP) begin
                r_sum[c] <= '0;
                r_sq[c]  <= '0;
            end else if (r_vld1) begin
                r_sum[c] <= r_sum[c] + SW'(r_rd_data[PIX_W*c +: PIX_W]);
                r_sq[c]  <= r_sq[c] + QW'(16'(r_rd_data[PIX_W*c +: PIX_W])
                                          * 16'(r_rd_data[PIX_W*c +: PIX_W]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_done <= r_done;
            for (int c = 0; c < NCH; c++) begin
                if (r_state == ST_PASS_OUT) begin
                    r_o_pix[c] <= r_rd_data[PIX_W*c +: PIX_W];
                end else begin
                    r_o_pix[c] <= mean[c];
                end
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_blue_out   = r_o_pix[0];
    assign o_green_out  = r_o_pix[1];
    assign o_red_out    = r_o_pix[2];
    assign o_frame_done = r_o_done;

`ifndef SYNTHESIS
    a_acc_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> $past(r_state) == ST_SUM) else $error("accumulate without a read");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_ROUND)
        |-> (r_rem[0] < n_val && r_rem[1] < n_val && r_rem[2] < n_val))
        else $error("divider remainder out of range");
    a_pass_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PASS_OUT
        |-> ($past(r_state) == ST_PASS_RD || $past(r_state) == ST_PASS_OUT))
        else $error("pass-through output without read");
`endif

endmodule

[src/kuwahara_color_filter_top.sv]
// Top level of the four-quadrant Kuwahara color filter.
// Instantiates kcf_front, kcf_job_queue and kcf_back; depends on kcf_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  pixel in | i_valid / o_stall  | i_blue_in, i_green_in, i_red_in, i_flush
//  pixel out| o_valid / i_stall  | o_blue_out, o_green_out, o_red_out, o_frame_done
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Edge pixels are read straight from the line store; filtered pixels are paced by
// the single line store read port that the quadrant sums read pixel by pixel.
// The front runs up to four results ahead through the job queue.
// Reset is synchronous, active low; the line store is not cleared.
// Output stalls hold the back. The front stalls on a full queue and, with a result
// pending, on a word that emits none, opens a frame or overwrites lines it reads.
module kuwahara_color_filter_top import kcf_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_blue_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic                  i_flush,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_blue_out,
    output logic [PIX_W-1:0]      o_green_out,
    output logic [PIX_W-1:0]      o_red_out,
    output logic                  o_frame_done,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int SLOTS = 2 * MAX_RADIUS + 1;
    localparam int SLW   = $clog2(SLOTS);
    localparam int AW    = $clog2(SLOTS * MAX_WIDTH);
    localparam int JW    = 2 + SLW + CLW;

    t_q_status          status;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [3*PIX_W-1:0] wr_data;
    logic               push;
    logic [JW-1:0]      job_in;
    logic               job_valid;
    logic [JW-1:0]      job_out;
    logic               pop;
    logic [QCW-1:0]     q_level;
    logic               back_busy;
    logic [RW-1:0]      radius;

    assign status.level = q_level;
    assign status.busy  = back_busy;

    kcf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_blue_in  (i_blue_in),
        .i_green_in (i_green_in),
        .i_red_in   (i_red_in),
        .i_flush    (i_flush),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_status   (status),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_push     (push),
        .o_job      (job_in),
        .o_radius   (radius)
    );

    kcf_job_queue #(
        .JW (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (job_out),
        .o_level (q_level)
    );

    kcf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_job_valid  (job_valid),
        .i_job        (job_out),
        .o_pop        (pop),
        .i_radius     (radius),
        .o_busy       (back_busy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_blue_out   (o_blue_out),
        .o_green_out  (o_green_out),
        .o_red_out    (o_red_out),
        .o_frame_done (o_frame_done)
    );

endmodule
